// ===== sv/edit_distance_engine_macros.svh =====
// Assertion macros shared by the edit distance engine checkers.
// Depends on nothing; included by the checker file.
`ifndef EDIT_DISTANCE_ENGINE_MACROS_SVH
`define EDIT_DISTANCE_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on the rising edge and disabled during reset.
`define ED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edit distance engine check failed");

// Next-cycle implication, sampled on the rising edge and disabled during reset.
`define ED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edit distance engine check failed");

`endif

// ===== sv/ed_pkg.sv =====
// Shared types, constants and the case-folding function of the edit distance engine.
// Depends on nothing; used by the interfaces, the top level and the checker.
package ed_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int ACT_W       = 2;
    localparam int CH_W        = 8;
    localparam int DIST_W      = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_FEED   = 2'd1,
        ACT_REPORT = 2'd2
    } action_t;

    // Folds ASCII upper-case letters to lower case when folding is enabled.
    function automatic logic [CH_W-1:0] fold_byte(input logic [CH_W-1:0] c,
                                                  input logic          fold_en);
        logic [CH_W-1:0] r;
        r = c;
        if (fold_en && c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== sv/ed_if.sv =====
// Handshake interfaces of the edit distance engine: item input, result output and
// configuration write channel. Depends on ed_pkg.
interface ed_in_if;
    logic            valid;
    logic            ready;
    ed_pkg::action_t action;
    logic [7:0]      ch;

    modport source (output valid, output action, output ch, input ready);
    modport sink   (input valid, input action, input ch, output ready);
endinterface

interface ed_out_if;
    logic                      valid;
    logic                      ready;
    logic [ed_pkg::DIST_W-1:0] distance;
    logic                      overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink   (input valid, input distance, input overflow, output ready);
endinterface

interface ed_cfg_if;
    logic valid;
    logic ready;
    logic ignore_case;

    modport source (output valid, output ignore_case, input ready);
    modport sink   (input valid, input ignore_case, output ready);
endinterface

// ===== sv/ed_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module ed_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/edit_distance_engine.sv =====
// Top level of the Levenshtein edit distance engine: control, row update datapath
// and the two RAMs. Depends on ed_pkg, ed_if (interfaces) and ed_ram.
//
//   Channel  Dir  Handshake      Payload
//   cfg      in   valid/ready    ignore_case
//   din      in   valid/ready    action, ch
//   dout     out  valid/ready    distance, overflow
//
// A load item leaves the block idle and ready for the next item. A feed item sweeps
// the cost-row RAM one entry per cycle, one entry per loaded byte of the second
// string, through the single read and write port of that RAM.
// A report item waits for the registered RAM read and for the output register to
// drain. Reset clears all counters and flags; no clearing pass is run.
// A configuration write is taken in any cycle; cfg.ready is always high.
module edit_distance_engine #(
    parameter int MAX_LEN = ed_pkg::MAX_LEN_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    ed_cfg_if.sink cfg,
    ed_in_if.sink  din,
    ed_out_if.source dout
);
    import ed_pkg::*;

    // Counters hold values up to MAX_LEN; the RAMs are MAX_LEN entries deep.
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = LW;
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_RPT
    } state_t;

    state_t              state_reg, state_next;
    logic                ignore_case_reg, ignore_case_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [LW-1:0]       cnt_reg, cnt_next;
    logic                drop_reg, drop_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [CH_W-1:0]     b_reg, b_next;
    logic [CW-1:0]       diag_reg, diag_next;
    logic [CW-1:0]       left_reg, left_next;
    logic                out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]   distance_reg, distance_next;
    logic                overflow_reg, overflow_next;

    logic                in_fire;
    logic                out_free;
    logic [CH_W-1:0]     folded;
    logic                len_full;
    logic                cnt_full;
    logic                last_cell;
    logic [AW-1:0]       len_m1;
    logic [AW-1:0]       rd_addr;
    logic                str_we;
    logic                cost_we;
    logic [AW-1:0]       cost_waddr;
    logic [CW-1:0]       cost_wdata;
    logic [CH_W-1:0]     str_q;
    logic [CW-1:0]       cost_q;
    logic [CW-1:0]       min_ul;
    logic [CW-1:0]       min_all;
    logic [CW-1:0]       best;

    // The second string lives in one RAM; cost_row entries 1..MAX_LEN live in the
    // other at address j-1. Entry zero always equals the feed count, so cnt_reg
    // stands in for it and needs no storage of its own.
    ed_ram #(
        .WIDTH (CH_W),
        .DEPTH (MAX_LEN)
    ) u_str_ram (
        .clk   (clk),
        .we    (str_we),
        .waddr (AW'(len_reg)),
        .wdata (folded),
        .raddr (rd_addr),
        .rdata (str_q)
    );

    ed_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_LEN)
    ) u_cost_ram (
        .clk   (clk),
        .we    (cost_we),
        .waddr (cost_waddr),
        .wdata (cost_wdata),
        .raddr (rd_addr),
        .rdata (cost_q)
    );

    assign cfg.ready     = 1'b1;
    assign din.ready     = (state_reg == S_IDLE);
    assign dout.valid    = out_valid_reg;
    assign dout.distance = distance_reg;
    assign dout.overflow = overflow_reg;

    assign in_fire  = din.valid && din.ready;
    assign out_free = !out_valid_reg || dout.ready;
    assign folded   = fold_byte(din.ch, ignore_case_reg);
    assign len_full = (len_reg == LW'(MAX_LEN));
    assign cnt_full = (cnt_reg == LW'(MAX_LEN));
    assign len_m1   = AW'(len_reg - LW'(1));
    assign last_cell = (LW'(idx_reg) == (len_reg - LW'(1)));

    // A load writes the folded byte and the fresh row entry j at position j-1.
    // During a feed sweep the cost RAM is written at the cell just read.
    assign str_we     = in_fire && (din.action == ACT_LOAD) && !len_full;
    assign cost_we    = str_we || (state_reg == S_FEED);
    assign cost_waddr = (state_reg == S_FEED) ? idx_reg : AW'(len_reg);
    assign cost_wdata = (state_reg == S_FEED) ? best : CW'(len_reg + LW'(1));

    // The read address runs one cell ahead of the write address during a sweep,
    // so a read never meets a write to the same entry. A report holds its
    // address until the result is placed in the output register.
    always_comb
    begin
        priority if (state_reg == S_FEED)
        begin
            rd_addr = AW'(idx_reg + AW'(1));
        end
        else if (state_reg == S_RPT || din.action == ACT_REPORT)
        begin
            rd_addr = len_m1;
        end
        else
        begin
            rd_addr = '0;
        end
    end

    // One cell of the table: up comes from the RAM, left is the cell just
    // computed, diag is the old value of the cell to the left.
    assign min_ul  = (cost_q < left_reg) ? cost_q : left_reg;
    assign min_all = (min_ul < diag_reg) ? min_ul : diag_reg;
    assign best    = (str_q == b_reg) ? diag_reg : CW'(min_all + CW'(1));

    always_comb
    begin
        state_next       = state_reg;
        ignore_case_next = ignore_case_reg;
        len_next         = len_reg;
        cnt_next         = cnt_reg;
        drop_next        = drop_reg;
        idx_next         = idx_reg;
        b_next           = b_reg;
        diag_next        = diag_reg;
        left_next        = left_reg;
        out_valid_next   = out_valid_reg;
        distance_next    = distance_reg;
        overflow_next    = overflow_reg;

        if (cfg.valid && cfg.ready)
        begin
            ignore_case_next = cfg.ignore_case;
        end

        if (out_valid_reg && dout.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (din.action)
                        ACT_LOAD:
                        begin
                            if (len_full)
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                len_next = len_reg + LW'(1);
                            end
                        end
                        ACT_FEED:
                        begin
                            if (cnt_full)
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                // Entry zero moves from the old count to the new one.
                                b_next    = folded;
                                diag_next = cnt_reg;
                                left_next = cnt_reg + LW'(1);
                                cnt_next  = cnt_reg + LW'(1);
                                idx_next  = '0;
                                if (len_reg != '0)
                                begin
                                    state_next = S_FEED;
                                end
                            end
                        end
                        ACT_REPORT:
                        begin
                            state_next = S_RPT;
                        end
                        default:
                        begin
                            // The unused action code is taken and does nothing.
                        end
                    endcase
                end
            end
            S_FEED:
            begin
                diag_next = cost_q;
                left_next = best;
                idx_next  = AW'(idx_reg + AW'(1));
                if (last_cell)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RPT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    distance_next  = (len_reg == '0) ? DIST_W'(cnt_reg) : DIST_W'(cost_q);
                    overflow_next  = drop_reg;
                    len_next       = '0;
                    cnt_next       = '0;
                    drop_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ignore_case_reg <= 1'b0;
            len_reg         <= '0;
            cnt_reg         <= '0;
            drop_reg        <= 1'b0;
            idx_reg         <= '0;
            b_reg           <= '0;
            diag_reg        <= '0;
            left_reg        <= '0;
            out_valid_reg   <= 1'b0;
            distance_reg    <= '0;
            overflow_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ignore_case_reg <= ignore_case_next;
            len_reg         <= len_next;
            cnt_reg         <= cnt_next;
            drop_reg        <= drop_next;
            idx_reg         <= idx_next;
            b_reg           <= b_next;
            diag_reg        <= diag_next;
            left_reg        <= left_next;
            out_valid_reg   <= out_valid_next;
            distance_reg    <= distance_next;
            overflow_reg    <= overflow_next;
        end
    end

endmodule

// ===== sv/ed_checker.sv =====
// Port-level checker for the edit distance engine and its bind to the top level.
// Depends on ed_pkg and edit_distance_engine_macros.svh.
`include "edit_distance_engine_macros.svh"

module ed_checker #(
    parameter int MAX_LEN = ed_pkg::MAX_LEN_DEF
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [ed_pkg::ACT_W-1:0]  in_action,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [ed_pkg::DIST_W-1:0] distance,
    input logic                      overflow
);
    import ed_pkg::*;

    // A stalled result keeps its valid and its payload.
    `ED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(distance) && $stable(overflow))

    // A report needs a RAM read, so the input side is busy in the next cycle.
    `ED_ASSERT_NEXT(a_report_busy, clk, rst_n, in_valid && in_ready && in_action == ACT_REPORT, !in_ready)

    // A load finishes in its own cycle and leaves the block ready.
    `ED_ASSERT_NEXT(a_load_single, clk, rst_n, in_valid && in_ready && in_action == ACT_LOAD, in_ready)

    // The distance never exceeds the longest string the block can hold.
    `ED_ASSERT_IMP(a_dist_range, clk, rst_n, out_valid, (MAX_LEN > 127) || (int'(distance) <= MAX_LEN))

endmodule

bind edit_distance_engine ed_checker #(
    .MAX_LEN (MAX_LEN)
) u_ed_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .in_action (din.action),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .distance  (dout.distance),
    .overflow  (dout.overflow)
);

// ===== tb/edit_distance_engine_test.sv =====
// Self-checking testbench for the edit distance engine: directed script, then random pairs.
// Depends on ed_pkg, the ed_if interfaces and the edit_distance_engine top level.
`timescale 1ns / 1ps

module edit_distance_engine_test;

    import ed_pkg::*;

    localparam int MAX_LEN      = MAX_LEN_DEF;
    localparam int RANDOM_ITEMS = 480;
    // The slowest correct run stays far below this many cycles.
    localparam int CYCLE_LIMIT  = 600000;
    // Action code 3 is not a member of action_t; the block must ignore it.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } score_t;

    typedef enum logic {
        STEP_ITEM,
        STEP_FOLD
    } step_kind_t;

    // One row of the directed script. A FOLD row writes ch[0] to ignore_case.
    // When typed is set, exp_dist and ovf are the expected result of a report row
    // and replace the predicted one.
    typedef struct packed {
        step_kind_t        kind;
        logic [ACT_W-1:0]  act;
        logic [CH_W-1:0]   ch;
        int                reps;
        logic              typed;
        logic [DIST_W-1:0] exp_dist;
        logic              ovf;
    } step_row_t;

    localparam int SCRIPT_LEN = 33;
    localparam step_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
        // A report straight after reset sees two empty strings.
        '{STEP_ITEM, ACT_REPORT, 8'h00, 1,  1'b1, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_UNUSED, 8'hFF, 1,  1'b0, 7'd0,  1'b0},
        // Single zero byte on both sides matches.
        '{STEP_ITEM, ACT_LOAD,   8'h00, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_FEED,   8'h00, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_REPORT, 8'h00, 1,  1'b1, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_LOAD,   8'hFF, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_LOAD,   8'h61, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_FEED,   8'h61, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_REPORT, 8'h00, 1,  1'b0, 7'd0,  1'b0},
        // Folding on: both ends of the upper-case range fold to lower case.
        '{STEP_FOLD, ACT_LOAD,   8'h01, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_LOAD,   8'h41, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_LOAD,   8'h5A, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_FEED,   8'h61, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_FEED,   8'h7A, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_REPORT, 8'h00, 1,  1'b1, 7'd0,  1'b0},
        // The byte just below 'A' is not folded, so it stays distinct from 0x60.
        '{STEP_ITEM, ACT_LOAD,   8'h40, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_FEED,   8'h60, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_REPORT, 8'h00, 1,  1'b1, 7'd1,  1'b0},
        // A load after a feed starts its column fresh, without replaying feeds.
        '{STEP_ITEM, ACT_LOAD,   8'h78, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_FEED,   8'h58, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_LOAD,   8'h79, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_FEED,   8'h5B, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_REPORT, 8'h00, 1,  1'b0, 7'd0,  1'b0},
        // Folding off again: case now matters.
        '{STEP_FOLD, ACT_LOAD,   8'h00, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_LOAD,   8'h41, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_FEED,   8'h61, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_REPORT, 8'h00, 1,  1'b1, 7'd1,  1'b0},
        // Too many second-string bytes: the last one is dropped.
        '{STEP_ITEM, ACT_LOAD,   8'hFF, 65, 1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_REPORT, 8'h00, 1,  1'b1, 7'd64, 1'b1},
        // Too many first-string bytes against an empty second string.
        '{STEP_ITEM, ACT_FEED,   8'h80, 65, 1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_REPORT, 8'h00, 1,  1'b1, 7'd64, 1'b1},
        // The unused action leaves the cleared pair untouched.
        '{STEP_ITEM, ACT_UNUSED, 8'h00, 1,  1'b0, 7'd0,  1'b0},
        '{STEP_ITEM, ACT_REPORT, 8'h00, 1,  1'b1, 7'd0,  1'b0}
    };

    logic clk;
    logic rst_n;

    ed_cfg_if cfg_ch ();
    ed_in_if  din_ch ();
    ed_out_if dout_ch ();

    edit_distance_engine #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_ch),
        .din  (din_ch),
        .dout (dout_ch)
    );

    // Predictor state: a private copy of the second string, the cost row,
    // both string counters, the dropped-byte flag and the fold setting.
    logic [CH_W-1:0] pred_second [MAX_LEN];
    int              pred_row [MAX_LEN+1];
    int              pred_len_b;
    int              pred_len_a;
    logic            pred_dropped;
    logic            pred_fold;

    // Scores predicted for accepted report items, oldest first.
    score_t expected_scores [$];

    int  mismatch_count;
    int  items_sent;
    int  cycle_count;
    bit  src_gaps_on;
    bit  snk_stalls_on;
    bit  paused_once;

    always #6 clk = ~clk;

    // Every driven signal is known from time zero.
    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.ignore_case  = 1'b0;
        din_ch.valid        = 1'b0;
        din_ch.action       = ACT_LOAD;
        din_ch.ch           = '0;
        dout_ch.ready       = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic logic [CH_W-1:0] lower_ascii(input logic [CH_W-1:0] c);
        if (pred_fold && c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    task automatic clear_prediction();
        for (int j = 0; j <= MAX_LEN; j++)
        begin
            pred_row[j] = 0;
        end
        for (int j = 0; j < MAX_LEN; j++)
        begin
            pred_second[j] = '0;
        end
        pred_len_b   = 0;
        pred_len_a   = 0;
        pred_dropped = 1'b0;
    endtask

    // Advances the predicted state by one accepted item. Only a report item
    // yields a score, which the row entry at the second string's length holds.
    task automatic predict_item(input logic [ACT_W-1:0] a, input logic [CH_W-1:0] c,
                                output bit has_score, output score_t score);
        logic [CH_W-1:0] b;
        int              diag;
        int              up;
        int              left;
        int              best;
        has_score = 1'b0;
        score     = '0;
        case (a)
            ACT_LOAD:
            begin
                if (pred_len_b >= MAX_LEN)
                begin
                    pred_dropped = 1'b1;
                end
                else
                begin
                    pred_second[pred_len_b] = lower_ascii(c);
                    pred_len_b++;
                    pred_row[pred_len_b] = pred_len_b;
                end
            end
            ACT_FEED:
            begin
                if (pred_len_a >= MAX_LEN)
                begin
                    pred_dropped = 1'b1;
                end
                else
                begin
                    b = lower_ascii(c);
                    pred_len_a++;
                    diag        = pred_row[0];
                    pred_row[0] = pred_len_a;
                    for (int j = 1; j <= pred_len_b; j++)
                    begin
                        up   = pred_row[j];
                        left = pred_row[j-1];
                        if (pred_second[j-1] == b)
                        begin
                            best = diag;
                        end
                        else
                        begin
                            best = up;
                            if (left < best) best = left;
                            if (diag < best) best = diag;
                            best = best + 1;
                        end
                        diag        = up;
                        pred_row[j] = best;
                    end
                end
            end
            ACT_REPORT:
            begin
                score.distance = pred_row[pred_len_b][DIST_W-1:0];
                score.overflow = pred_dropped;
                has_score      = 1'b1;
                clear_prediction();
            end
            default:
            begin
            end
        endcase
    endtask

    // Offers one item on the input channel after a random gap and holds it
    // until the block takes it. With no gap, valid stays high from the
    // previous item and only the payload changes at the falling edge.
    task automatic send_item(input logic [ACT_W-1:0] a, input logic [CH_W-1:0] c,
                             input bit typed, input score_t typed_score);
        int     gap;
        bit     has_score;
        score_t score;
        gap = src_gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            din_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        din_ch.valid  <= 1'b1;
        din_ch.action <= action_t'(a);
        din_ch.ch     <= c;
        do @(posedge clk); while (din_ch.ready !== 1'b1);
        predict_item(a, c, has_score, score);
        if (has_score)
        begin
            expected_scores = {expected_scores, (typed ? typed_score : score)};
        end
        if (a != ACT_UNUSED)
        begin
            items_sent++;
        end
    endtask

    // Stops offering items and waits for every predicted score. With settle
    // set, it also waits out the longest row sweep, since a feed item gives
    // no result that would show when the block has finished it.
    task automatic drain(input bit settle);
        @(negedge clk);
        din_ch.valid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge clk);
        if (settle)
        begin
            repeat (MAX_LEN + 8) @(posedge clk);
        end
    endtask

    // The fold setting is written only with the block idle.
    task automatic write_fold(input logic v);
        drain(1'b1);
        @(negedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.ignore_case <= v;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        pred_fold = v;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Most bytes come from a few letters in both cases, so that matches and
    // folding matter; the rest cover the whole byte range.
    function automatic logic [CH_W-1:0] pick_byte();
        if ($urandom_range(0, 99) < 60)
        begin
            return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 2));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // One random pair. Most pairs are well formed: loads, feeds, perhaps some
    // late loads, then a report. Lengths are mostly short; a few go past
    // MAX_LEN on one side or the other. The rest is noise with any action,
    // which may leave a pair open for the next one.
    task automatic run_pair();
        int r;
        int len_b;
        int len_a;
        int late;
        int n;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            len_b = $urandom_range(56, 70);
            len_a = $urandom_range(0, 70);
        end
        else if (r < 9)
        begin
            len_b = $urandom_range(0, 4);
            len_a = $urandom_range(60, 70);
        end
        else
        begin
            len_b = $urandom_range(0, 10);
            len_a = $urandom_range(0, 10);
        end
        if ($urandom_range(0, 99) < 12)
        begin
            n = $urandom_range(1, 12);
            repeat (n)
            begin
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, '0);
            end
            if ($urandom_range(0, 1))
            begin
                send_item(ACT_REPORT, 8'($urandom_range(0, 255)), 1'b0, '0);
            end
        end
        else
        begin
            late = ($urandom_range(0, 99) < 15) ? $urandom_range(0, len_b) : 0;
            repeat (len_b - late) send_item(ACT_LOAD, pick_byte(), 1'b0, '0);
            repeat (len_a) send_item(ACT_FEED, pick_byte(), 1'b0, '0);
            repeat (late) send_item(ACT_LOAD, pick_byte(), 1'b0, '0);
            send_item(ACT_REPORT, 8'($urandom_range(0, 255)), 1'b0, '0);
        end
    endtask

    // Result side: a random stall before each result, then ready stays high
    // until one is taken. Each taken result is checked against the oldest
    // predicted score.
    initial
    begin
        int     stall;
        score_t want;
        forever
        begin
            stall = snk_stalls_on ? $urandom_range(0, 19) : 0;
            if (stall > 0)
            begin
                @(negedge clk);
                dout_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            dout_ch.ready <= 1'b1;
            do @(posedge clk); while (!(rst_n === 1'b1 && dout_ch.valid === 1'b1));
            if (expected_scores.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: distance %0d overflow %0b",
                                          dout_ch.distance, dout_ch.overflow));
            end
            else
            begin
                want = expected_scores.pop_front();
                if (dout_ch.distance !== want.distance)
                begin
                    report_mismatch($sformatf("distance: got %0d, predicted %0d",
                                              dout_ch.distance, want.distance));
                end
                if (dout_ch.overflow !== want.overflow)
                begin
                    report_mismatch($sformatf("overflow: got %0b, predicted %0b",
                                              dout_ch.overflow, want.overflow));
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main sequence: reset, the directed script, random phases, then the
    // final drain and verdict.
    initial
    begin
        step_row_t row;
        int        phase_pairs;
        mismatch_count = 0;
        items_sent     = 0;
        paused_once    = 1'b0;
        src_gaps_on    = 1'b1;
        snk_stalls_on  = 1'b1;
        pred_fold      = 1'b0;
        clear_prediction();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            row = SCRIPT[i];
            if (row.kind == STEP_FOLD)
            begin
                write_fold(row.ch[0]);
            end
            else
            begin
                repeat (row.reps)
                begin
                    send_item(row.act, row.ch, row.typed, '{row.exp_dist, row.ovf});
                end
            end
        end

        // Random phases, each with its own fold setting and idling mode. Some
        // phases run with no gaps or no stalls at all.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            write_fold($urandom_range(0, 1));
            src_gaps_on   = ($urandom_range(0, 3) != 0);
            snk_stalls_on = ($urandom_range(0, 3) != 0);
            phase_pairs   = $urandom_range(1, 6);
            repeat (phase_pairs)
            begin
                run_pair();
                // Now and then the sender holds off until every score is back.
                if (!paused_once || $urandom_range(0, 9) == 0)
                begin
                    drain(1'b0);
                    paused_once = 1'b1;
                end
            end
        end

        drain(1'b1);
        repeat (MAX_LEN + 8) @(posedge clk);
        if (expected_scores.size() != 0)
        begin
            report_mismatch($sformatf("%0d predicted scores never arrived",
                                      expected_scores.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
